@@ rtl/core/cfs_pkg.sv @@
// Shared types and constants for the CAN frame segmenter.
// No dependencies; imported by every module of the block.
package cfs_pkg;

	localparam int unsigned CFS_MAX_FRAMES  = 255;
	localparam int unsigned CFS_FRAME_BYTES = 8;
	localparam logic [10:0] CFS_LEN_CAP     = 11'(CFS_MAX_FRAMES * CFS_FRAME_BYTES);

	// Queue between front and back; depth must be a power of two.
	localparam int unsigned CFS_MQ_DEPTH = 4;
	localparam int unsigned CFS_MQ_PTR_W = $clog2(CFS_MQ_DEPTH);
	localparam int unsigned CFS_MQ_CNT_W = $clog2(CFS_MQ_DEPTH + 1);

	// Result queue; depth must be a power of two.
	localparam int unsigned CFS_OQ_DEPTH = 4;
	localparam int unsigned CFS_OQ_PTR_W = $clog2(CFS_OQ_DEPTH);
	localparam int unsigned CFS_OQ_CNT_W = $clog2(CFS_OQ_DEPTH + 1);

	localparam int unsigned CFS_CFG_IDX_W = 4;
	localparam logic [CFS_CFG_IDX_W-1:0] CFS_REG_EXT_SINGLE = 4'd0;
	localparam logic [CFS_CFG_IDX_W-1:0] CFS_REG_STD_SINGLE = 4'd1;

	// One classified byte as handed from front to back.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       start;
		logic       zero_len;
		logic       last;
		logic [4:0] kind;
		logic [7:0] rx;
		logic [7:0] tx;
		logic [7:0] frames_total;
	} cfs_item_t;

	typedef struct packed {
		logic [28:0] id;
		logic [63:0] data;
		logic [3:0]  length;
		logic        last;
	} cfs_frame_t;

	typedef struct packed {
		logic [4:0] ext_code;
		logic [4:0] std_code;
	} cfs_cfg_t;

endpackage

@@ rtl/core/cfs_front.sv @@
// Front end: accepts bytes, tracks message boundaries, queues classified items.
// Depends on cfs_pkg.
module cfs_front import cfs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  payload_byte,
	input  logic [10:0] msg_length,
	input  logic [7:0]  receiver_addr,
	input  logic [7:0]  sender_addr,
	input  logic [4:0]  msg_kind,
	output logic        q_valid,
	output cfs_item_t   q_item,
	input  logic        q_pop
);

	logic                    in_msg_q;
	logic [10:0]             bytes_rem_q;
	logic [CFS_MQ_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CFS_MQ_CNT_W-1:0] cnt_q;
	cfs_item_t               mem_q [CFS_MQ_DEPTH];

	logic        accept, do_pop;
	logic [10:0] len_sat, len_sum, rem_cur;
	cfs_item_t   item;

	assign full    = (cnt_q == CFS_MQ_CNT_W'(CFS_MQ_DEPTH));
	assign accept  = push & ~full;
	assign q_valid = (cnt_q != '0);
	assign do_pop  = q_pop & q_valid;
	assign q_item  = mem_q[rd_ptr_q];

	always_comb begin
		len_sat = (msg_length > CFS_LEN_CAP) ? CFS_LEN_CAP : msg_length;
		len_sum = len_sat + 11'd7;   // capped length keeps this inside 11 bits
		rem_cur = in_msg_q ? bytes_rem_q : len_sat;
		item.data_byte    = payload_byte;
		item.zero_len     = ~in_msg_q & (len_sat == '0);
		item.start        = ~in_msg_q & (len_sat != '0);
		item.last         = (rem_cur == 11'd1);
		item.kind         = msg_kind;
		item.rx           = receiver_addr;
		item.tx           = sender_addr;
		item.frames_total = len_sum[10:3];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_msg_q    <= 1'b0;
			bytes_rem_q <= '0;
		end else if (accept && !item.zero_len) begin
			bytes_rem_q <= rem_cur - 11'd1;
			in_msg_q    <= (rem_cur != 11'd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (accept)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({accept, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			mem_q[wr_ptr_q] <= item;
	end

endmodule

@@ rtl/core/cfs_back.sv @@
// Back end: packs queued bytes into frames, builds the ID, holds the result queue.
// Depends on cfs_pkg.
module cfs_back import cfs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cfs_cfg_t    cfg,
	input  logic        q_valid,
	input  cfs_item_t   q_item,
	output logic        q_pop,
	output logic        empty,
	input  logic        pop,
	output logic [28:0] frame_id,
	output logic [63:0] frame_data,
	output logic [3:0]  frame_length,
	output logic        last_frame
);

	logic [4:0]  kind_q;
	logic [7:0]  rx_q, tx_q, ftot_q, idx_q;
	logic [63:0] buf_q;
	logic [3:0]  fill_q;

	logic [CFS_OQ_PTR_W-1:0] oq_wr_q, oq_rd_q;
	logic [CFS_OQ_CNT_W-1:0] oq_cnt_q;
	cfs_frame_t              oq_mem_q [CFS_OQ_DEPTH];

	logic        oq_push, oq_pop, emit;
	logic [4:0]  kind, id_kind;
	logic [7:0]  rx, tx, ftot, idx, seq;
	logic [63:0] base_buf, new_buf;
	logic [3:0]  base_fill, new_fill;
	cfs_frame_t  frame, head;

	assign q_pop  = q_valid & (oq_cnt_q != CFS_OQ_CNT_W'(CFS_OQ_DEPTH));
	assign empty  = (oq_cnt_q == '0);
	assign oq_pop = pop & ~empty;
	assign oq_push = q_pop & emit;

	assign head         = oq_mem_q[oq_rd_q];
	assign frame_id     = head.id;
	assign frame_data   = head.data;
	assign frame_length = head.length;
	assign last_frame   = head.last;

	always_comb begin
		kind      = q_item.start ? q_item.kind : kind_q;
		rx        = q_item.start ? q_item.rx : rx_q;
		tx        = q_item.start ? q_item.tx : tx_q;
		ftot      = q_item.start ? q_item.frames_total : ftot_q;
		idx       = q_item.start ? 8'd0 : idx_q;
		base_buf  = q_item.start ? 64'd0 : buf_q;
		base_fill = q_item.start ? 4'd0 : fill_q;
		// byte lands at bit 56 - 8*fill, i.e. 8*(7 - fill)
		new_buf   = base_buf | ({56'd0, q_item.data_byte} << {~base_fill[2:0], 3'b000});
		new_fill  = base_fill + 4'd1;
		seq       = ftot - idx;
		id_kind   = kind;
		if (ftot > 8'd1 && idx == 8'd0 && kind == cfg.ext_code)
			id_kind = cfg.std_code;
		if (q_item.zero_len) begin
			emit         = 1'b1;
			frame.id     = {q_item.kind, q_item.rx, q_item.tx, 8'd1};
			frame.data   = '0;
			frame.length = '0;
			frame.last   = 1'b1;
		end else begin
			emit         = new_fill[3] | q_item.last;
			frame.id     = {id_kind, rx, tx, seq};
			frame.data   = new_buf;
			frame.length = new_fill;
			frame.last   = q_item.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			idx_q  <= '0;
		end else if (q_pop && !q_item.zero_len) begin
			if (emit) begin
				fill_q <= '0;
				idx_q  <= idx + 8'd1;
			end else begin
				fill_q <= new_fill;
				idx_q  <= idx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && !q_item.zero_len) begin
			kind_q <= kind;
			rx_q   <= rx;
			tx_q   <= tx;
			ftot_q <= ftot;
			buf_q  <= emit ? 64'd0 : new_buf;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wr_q  <= '0;
			oq_rd_q  <= '0;
			oq_cnt_q <= '0;
		end else begin
			if (oq_push)
				oq_wr_q <= oq_wr_q + 1'b1;
			if (oq_pop)
				oq_rd_q <= oq_rd_q + 1'b1;
			case ({oq_push, oq_pop})
				2'b10:   oq_cnt_q <= oq_cnt_q + 1'b1;
				2'b01:   oq_cnt_q <= oq_cnt_q - 1'b1;
				default: oq_cnt_q <= oq_cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (oq_push)
			oq_mem_q[oq_wr_q] <= frame;
	end

	a_oq_bound: assert property (@(posedge clk) disable iff (!arst_n)
		oq_cnt_q <= CFS_OQ_CNT_W'(CFS_OQ_DEPTH))
		else $error("result queue count out of range");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= 4'd7)
		else $error("partial frame holds eight bytes");

	a_fill_clear: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop && emit |=> fill_q == 4'd0)
		else $error("fill not cleared after frame transaction");

	a_last_len: assert property (@(posedge clk) disable iff (!arst_n)
		oq_push && !frame.last |-> frame.length == 4'd8)
		else $error("non-final frame is not full");

endmodule

@@ rtl/core/can_frame_segmenter.sv @@
// Top level of the CAN frame segmenter: configuration registers, front and back.
// Depends on cfs_pkg, cfs_front, cfs_back.
//
// Splits a message, given one payload byte per input transaction, into CAN
// frames with 29-bit extended IDs. The transaction that starts a message also
// carries length and header; up to eight bytes go into a frame, the first in
// frame_data[63:56]. The block takes one byte per clock while full is low. An
// accepted byte is classified into a 4-entry queue and packed by the back end
// when the result queue has room; a frame enters that queue, whose head drives
// the result ports, as its final byte is packed. Throughput is set by the
// single pack step in the back end; full rises only when the 4-entry classified
// queue fills, which happens when the 4-entry result queue backs up because pop
// is held low. Lengths above 2040 bytes are clipped to 2040. Configuration
// writes are always ready and must only be made while no message is in flight.
module can_frame_segmenter import cfs_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	output logic                     full,
	input  logic [7:0]               payload_byte,
	input  logic [10:0]              msg_length,
	input  logic [7:0]               receiver_addr,
	input  logic [7:0]               sender_addr,
	input  logic [4:0]               msg_kind,
	output logic                     empty,
	input  logic                     pop,
	output logic [28:0]              frame_id,
	output logic [63:0]              frame_data,
	output logic [3:0]               frame_length,
	output logic                     last_frame,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFS_CFG_IDX_W-1:0] cfg_index,
	input  logic [4:0]               cfg_data
);

	cfs_cfg_t  cfg_q;
	logic      q_valid, q_pop;
	cfs_item_t q_item;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFS_REG_EXT_SINGLE: cfg_q.ext_code <= cfg_data;
				CFS_REG_STD_SINGLE: cfg_q.std_code <= cfg_data;
				default:            cfg_q <= cfg_q;
			endcase
		end
	end

	cfs_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.payload_byte  (payload_byte),
		.msg_length    (msg_length),
		.receiver_addr (receiver_addr),
		.sender_addr   (sender_addr),
		.msg_kind      (msg_kind),
		.q_valid       (q_valid),
		.q_item        (q_item),
		.q_pop         (q_pop)
	);

	cfs_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.q_valid      (q_valid),
		.q_item       (q_item),
		.q_pop        (q_pop),
		.empty        (empty),
		.pop          (pop),
		.frame_id     (frame_id),
		.frame_data   (frame_data),
		.frame_length (frame_length),
		.last_frame   (last_frame)
	);

endmodule
